FILE: hdl/modbus_rtu_response_deframer_macros.svh
// ---------------------------------------------------------------------------
// Modbus RTU reply deframer: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_DEFRAMER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_DEFRAMER_MACROS_SVH

// Same-cycle implication
`define MRTU_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication
`define MRTU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: hdl/mrtu_pkg.sv
// ---------------------------------------------------------------------------
// Modbus RTU reply deframer package
// Types, codes and the CRC-16/MODBUS byte update shared by the deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package mrtu_pkg;

	// Frame parser phase
	typedef enum logic [2:0] {
		PH_ADDR  = 3'd0,
		PH_FUNC  = 3'd1,
		PH_COUNT = 3'd2,
		PH_EXC   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CRC   = 3'd5
	} phase_t;

	// End-of-frame status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_CRC       = 3'd1,
		ST_ILLEGAL   = 3'd2,
		ST_COUNT     = 3'd3,
		ST_EXCEPTION = 3'd4,
		ST_TIMEOUT   = 3'd5
	} status_t;

	// Input operation codes
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// Result kinds
	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Supported function codes
	localparam logic [7:0] FC_READ_COILS      = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
	localparam logic [7:0] FC_READ_INPUT      = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
	localparam logic [7:0] FC_WRITE_REG       = 8'd6;
	localparam logic [7:0] FC_READ_EXC_STATUS = 8'd7;
	localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS      = 8'd16;
	localparam logic [7:0] FC_REPORT_ID       = 8'd17;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  MAX_COUNT_RESET = 8'd253;
	localparam logic [8:0]  LEN_SAT = 9'h1FF;

	// Per-frame parser state
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  bytes_left;
		logic [15:0] crc;
		logic [7:0]  addr;
		logic [8:0]  len;
	} frame_state_t;

	localparam frame_state_t FRAME_CLEAR = '{
		phase:      PH_ADDR,
		bytes_left: 8'd0,
		crc:        CRC_INIT,
		addr:       8'd0,
		len:        9'd0
	};

	// One result item
	typedef struct packed {
		logic        kind;
		logic [7:0]  pdu_byte;
		status_t     status;
		logic [7:0]  slave_addr;
		logic [7:0]  exception_code;
		logic [8:0]  pdu_length;
	} result_t;

	// CRC-16/MODBUS, one byte, reflected
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'd0, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/modbus_rtu_response_deframer.sv
// ---------------------------------------------------------------------------
// Modbus RTU reply deframer
// Parses reply frames, checks CRC-16/MODBUS, echoes PDU bytes, reports status.
// ---------------------------------------------------------------------------
// One byte or timeout event is taken every clock cycle while in_stall is low;
// each item passes from the input register through the combinational CRC
// byte update and phase decode, and any result it makes waits in the result
// register while out_stall is high; the input side stalls only when that
// register is full and not being taken. max_byte_count is written through
// cfg_wr_en and cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this. It resets to 253.
`default_nettype none

`include "modbus_rtu_response_deframer_macros.svh"

module modbus_rtu_response_deframer
	import mrtu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] rx_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] pdu_byte,
	output logic [2:0] status,
	output logic [7:0] slave_addr,
	output logic [7:0] exception_code,
	output logic [8:0] pdu_length
);

	logic         valid_s1;
	logic         op_s1;
	logic [7:0]   byte_s1;
	logic [7:0]   max_count_q;
	frame_state_t state_q;
	frame_state_t state_next;
	logic         res_valid;
	result_t      res;
	logic         out_valid_q;
	result_t      res_q;
	logic         out_free;
	logic         advance;
	logic         end_taken;
	logic         frame_idle;
	logic         echo_out;
	logic         echo_fields_zero;
	logic         len_shown;
	logic         end_ok;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= MAX_COUNT_RESET;
		end else if (cfg_wr_en) begin
			max_count_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	mrtu_frame_step u_step (
		.state          (state_q),
		.op             (op_s1),
		.rx_byte        (byte_s1),
		.max_byte_count (max_count_q),
		.next_state     (state_next),
		.res_valid      (res_valid),
		.res            (res)
	);

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRAME_CLEAR;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = res_q.kind;
	assign pdu_byte       = res_q.pdu_byte;
	assign status         = res_q.status;
	assign slave_addr     = res_q.slave_addr;
	assign exception_code = res_q.exception_code;
	assign pdu_length     = res_q.pdu_length;

	// Check terms
	assign end_taken  = advance && res_valid && res.kind == KIND_END;
	assign frame_idle = state_q.phase == PH_ADDR && state_q.crc == CRC_INIT
		&& state_q.len == 9'd0;
	assign echo_out   = out_valid_q && res_q.kind == KIND_ECHO;
	assign echo_fields_zero = res_q.status == ST_OK && res_q.slave_addr == 8'd0
		&& res_q.exception_code == 8'd0;
	assign len_shown  = out_valid_q && res_q.pdu_length != 9'd0;
	assign end_ok     = res_q.kind == KIND_END && res_q.status == ST_OK;

	// Checks
	`MRTU_ASSERT_NEXT(a_end_clears_frame, end_taken, frame_idle)
	`MRTU_ASSERT_IMPLY(a_echo_fields_clear, echo_out, echo_fields_zero)
	`MRTU_ASSERT_IMPLY(a_length_only_ok, len_shown, end_ok)

endmodule

`default_nettype wire

FILE: hdl/mrtu_frame_step.sv
// ---------------------------------------------------------------------------
// Modbus RTU frame step
// Next parser state and the result item for one received byte or timeout.
// ---------------------------------------------------------------------------
`default_nettype none

module mrtu_frame_step
	import mrtu_pkg::*;
(
	input  frame_state_t state,
	input  logic         op,
	input  logic [7:0]   rx_byte,
	input  logic [7:0]   max_byte_count,
	output frame_state_t next_state,
	output logic         res_valid,
	output result_t      res
);

	logic [15:0] crc_next;
	logic        func_known;
	logic [7:0]  func_len;
	logic        count_bad;

	assign crc_next  = crc16_byte(state.crc, rx_byte);
	assign count_bad = rx_byte > max_byte_count;

	// Function code decode: fixed tail length, or byte count when zero
	always_comb begin
		func_known = 1'b1;
		func_len   = 8'd0;
		case (rx_byte) inside
			FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
			FC_REPORT_ID: begin
				func_len = 8'd0;
			end
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
				func_len = 8'd4;
			end
			FC_READ_EXC_STATUS: begin
				func_len = 8'd1;
			end
			default: begin
				func_known = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		next_state     = state;
		next_state.crc = crc_next;
		if (op == OP_TIMEOUT) begin
			next_state = FRAME_CLEAR;
		end else begin
			case (state.phase)
				PH_FUNC: begin
					if (rx_byte[7]) begin
						next_state.phase = PH_EXC;
					end else if (!func_known) begin
						next_state = FRAME_CLEAR;
					end else if (func_len == 8'd0) begin
						next_state.phase = PH_COUNT;
					end else begin
						next_state.phase      = PH_DATA;
						next_state.bytes_left = func_len;
					end
				end
				PH_COUNT: begin
					if (count_bad) begin
						next_state = FRAME_CLEAR;
					end else if (rx_byte == 8'd0) begin
						next_state.phase      = PH_CRC;
						next_state.bytes_left = 8'd2;
					end else begin
						next_state.phase      = PH_DATA;
						next_state.bytes_left = rx_byte;
					end
				end
				PH_EXC: begin
					next_state = FRAME_CLEAR;
				end
				PH_DATA: begin
					if (state.bytes_left <= 8'd1) begin
						next_state.phase      = PH_CRC;
						next_state.bytes_left = 8'd2;
					end else begin
						next_state.bytes_left = state.bytes_left - 8'd1;
					end
				end
				PH_CRC: begin
					if (state.bytes_left > 8'd1) begin
						next_state.bytes_left = state.bytes_left - 8'd1;
					end else begin
						next_state = FRAME_CLEAR;
					end
				end
				default: begin
					// address phase, unused codes behave the same
					next_state.addr  = rx_byte;
					next_state.phase = PH_FUNC;
				end
			endcase
			// echoed bytes grow the PDU length
			if (res_valid && res.kind == KIND_ECHO && state.len != LEN_SAT) begin
				next_state.len = state.len + 9'd1;
			end
		end
	end

	// Result item
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = KIND_ECHO;
		res.pdu_byte       = rx_byte;
		res.status         = ST_OK;
		res.slave_addr     = 8'd0;
		res.exception_code = 8'd0;
		res.pdu_length     = 9'd0;
		if (op == OP_TIMEOUT) begin
			res_valid      = 1'b1;
			res.kind       = KIND_END;
			res.pdu_byte   = 8'd0;
			res.status     = ST_TIMEOUT;
			res.slave_addr = state.addr;
		end else begin
			case (state.phase)
				PH_FUNC: begin
					res_valid = 1'b1;
					if (!rx_byte[7] && !func_known) begin
						res.kind       = KIND_END;
						res.pdu_byte   = 8'd0;
						res.status     = ST_ILLEGAL;
						res.slave_addr = state.addr;
					end
				end
				PH_COUNT: begin
					res_valid = 1'b1;
					if (count_bad) begin
						res.kind       = KIND_END;
						res.pdu_byte   = 8'd0;
						res.status     = ST_COUNT;
						res.slave_addr = state.addr;
					end
				end
				PH_EXC: begin
					res_valid          = 1'b1;
					res.kind           = KIND_END;
					res.pdu_byte       = 8'd0;
					res.status         = ST_EXCEPTION;
					res.slave_addr     = state.addr;
					res.exception_code = rx_byte;
				end
				PH_DATA: begin
					res_valid = 1'b1;
				end
				PH_CRC: begin
					// last CRC byte closes the frame; residue must be zero
					if (state.bytes_left <= 8'd1) begin
						res_valid      = 1'b1;
						res.kind       = KIND_END;
						res.pdu_byte   = 8'd0;
						res.slave_addr = state.addr;
						if (crc_next == 16'd0) begin
							res.status     = ST_OK;
							res.pdu_length = state.len;
						end else begin
							res.status = ST_CRC;
						end
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// Modbus RTU reply deframer testbench
// Drives reply bytes and timeouts through the valid/stall input channel and
// checks every echo and end-of-frame result against an in-bench prediction
// of the parser, across several byte count limits and idling patterns.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrtu_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam logic [7:0] LEGAL_FC [10] = '{
		FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
		FC_WRITE_COIL, FC_WRITE_REG, FC_READ_EXC_STATUS, FC_WRITE_COILS,
		FC_WRITE_REGS, FC_REPORT_ID
	};

	// Frame parser prediction and result comparison
	class deframe_checker;
		logic [7:0]  count_limit;
		phase_t      ph;
		logic [7:0]  remaining;
		logic [15:0] crc_acc;
		logic [7:0]  addr_seen;
		logic [8:0]  pdu_count;
		result_t     awaited[$];
		int          errors;
		int          n_in;
		int          n_out;
		int          ok_frames;

		function new();
			count_limit = MAX_COUNT_RESET;
			restart_frame();
		endfunction

		// Reflected CRC-16, one data bit at a time
		static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c = c >> 1;
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		function void restart_frame();
			ph = PH_ADDR;
			remaining = 8'd0;
			crc_acc = CRC_INIT;
			addr_seen = 8'd0;
			pdu_count = 9'd0;
		endfunction

		function void push_echo(logic [7:0] b);
			result_t r;
			r.kind = KIND_ECHO;
			r.pdu_byte = b;
			r.status = ST_OK;
			r.slave_addr = 8'd0;
			r.exception_code = 8'd0;
			r.pdu_length = 9'd0;
			awaited.push_back(r);
			if (pdu_count != LEN_SAT) begin
				pdu_count = pdu_count + 9'd1;
			end
		endfunction

		function void push_end(status_t st, logic [7:0] exc);
			result_t r;
			r.kind = KIND_END;
			r.pdu_byte = 8'd0;
			r.status = st;
			r.slave_addr = addr_seen;
			r.exception_code = (st == ST_EXCEPTION) ? exc : 8'd0;
			r.pdu_length = (st == ST_OK) ? pdu_count : 9'd0;
			awaited.push_back(r);
			restart_frame();
		endfunction

		// Predict the results of one accepted input transaction
		function void accept_item(logic o, logic [7:0] b);
			n_in++;
			if (o == OP_TIMEOUT) begin
				push_end(ST_TIMEOUT, 8'd0);
				return;
			end
			crc_acc = crc_next(crc_acc, b);
			case (ph)
			PH_FUNC: begin
				if (b[7]) begin
					ph = PH_EXC;
					push_echo(b);
				end else begin
					case (b)
					FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
					FC_REPORT_ID: begin
						ph = PH_COUNT;
						push_echo(b);
					end
					FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
						ph = PH_DATA;
						remaining = 8'd4;
						push_echo(b);
					end
					FC_READ_EXC_STATUS: begin
						ph = PH_DATA;
						remaining = 8'd1;
						push_echo(b);
					end
					default: begin
						push_end(ST_ILLEGAL, 8'd0);
					end
					endcase
				end
			end
			PH_COUNT: begin
				if (b > count_limit) begin
					push_end(ST_COUNT, 8'd0);
				end else begin
					// zero count goes straight to the CRC bytes
					ph = (b == 8'd0) ? PH_CRC : PH_DATA;
					remaining = (b == 8'd0) ? 8'd2 : b;
					push_echo(b);
				end
			end
			PH_EXC: begin
				push_end(ST_EXCEPTION, b);
			end
			PH_DATA: begin
				if (remaining <= 8'd1) begin
					ph = PH_CRC;
					remaining = 8'd2;
				end else begin
					remaining = remaining - 8'd1;
				end
				push_echo(b);
			end
			PH_CRC: begin
				if (remaining > 8'd1) begin
					remaining = remaining - 8'd1;
				end else begin
					push_end((crc_acc == 16'd0) ? ST_OK : ST_CRC, 8'd0);
				end
			end
			default: begin
				addr_seen = b;
				ph = PH_FUNC;
			end
			endcase
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			errors++;
		endtask

		task cmp(string name, logic [8:0] got, logic [8:0] want);
			if (got !== want) begin
				report($sformatf("result %0d field %s got %0d want %0d",
					n_out, name, got, want));
			end
		endtask

		// Compare one accepted result with the oldest prediction
		task check_result(result_t got);
			result_t want;
			n_out++;
			if (awaited.size() == 0) begin
				report($sformatf("result %0d (kind %0d) arrived with none predicted",
					n_out, got.kind));
				return;
			end
			want = awaited.pop_front();
			if (want.kind == KIND_END && want.status == ST_OK) begin
				ok_frames++;
			end
			cmp("kind", got.kind, want.kind);
			cmp("pdu_byte", got.pdu_byte, want.pdu_byte);
			cmp("status", got.status, want.status);
			cmp("slave_addr", got.slave_addr, want.slave_addr);
			cmp("exception_code", got.exception_code, want.exception_code);
			cmp("pdu_length", got.pdu_length, want.pdu_length);
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_stall;
	logic       op;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic       kind;
	logic [7:0] pdu_byte;
	logic [2:0] status;
	logic [7:0] slave_addr;
	logic [7:0] exception_code;
	logic [8:0] pdu_length;

	deframe_checker sb = new;
	int             tx_idle = 35;
	int             rx_idle = 56;
	logic [7:0]     cur_max = MAX_COUNT_RESET;
	logic [7:0]     mid_max;

	modbus_rtu_response_deframer uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.pdu_byte       (pdu_byte),
		.status         (status),
		.slave_addr     (slave_addr),
		.exception_code (exception_code),
		.pdu_length     (pdu_length)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	initial begin
		#5ms;
		$display("modbus_rtu_response_deframer verification failed");
		$finish;
	end

	// Result side: take transactions, then pick the next stall
	initial begin
		result_t got;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.kind = kind;
				got.pdu_byte = pdu_byte;
				got.status = status_t'(status);
				got.slave_addr = slave_addr;
				got.exception_code = exception_code;
				got.pdu_length = pdu_length;
				sb.check_result(got);
			end
			out_stall <= ($urandom_range(99) < rx_idle);
		end
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic bit is_legal(logic [7:0] fc);
		foreach (LEGAL_FC[i]) begin
			if (LEGAL_FC[i] == fc) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Append the CRC low byte first, optionally with one bit flipped
	function automatic byte_q_t add_crc(byte_q_t q, bit corrupt);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (q[i]) begin
			c = deframe_checker::crc_next(c, q[i]);
		end
		if (corrupt) begin
			c = c ^ (16'd1 << $urandom_range(15));
		end
		q.push_back(c[7:0]);
		q.push_back(c[15:8]);
		return q;
	endfunction

	// Well-formed reply; an oversized count cuts the frame at the count byte
	function automatic byte_q_t legal_frame(bit corrupt);
		byte_q_t    q;
		logic [7:0] fc;
		logic [7:0] n;
		int         pick;
		q.push_back(rand_byte());
		fc = LEGAL_FC[$urandom_range(9)];
		q.push_back(fc);
		case (fc)
		FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
			repeat (4) q.push_back(rand_byte());
		end
		FC_READ_EXC_STATUS: begin
			q.push_back(rand_byte());
		end
		default: begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				n = 8'($urandom_range(0, (cur_max < 8'd12) ? cur_max : 12));
			end else if (pick < 85) begin
				n = 8'($urandom_range(0, 12));
			end else begin
				n = rand_byte();
			end
			q.push_back(n);
			if (n > cur_max) begin
				return q;
			end
			repeat (n) q.push_back(rand_byte());
		end
		endcase
		return add_crc(q, corrupt);
	endfunction

	// One input transaction, after a random gap
	task automatic send_item(logic o, logic [7:0] b);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.accept_item(o, b);
	endtask

	task automatic send_bytes(byte_q_t q);
		foreach (q[i]) begin
			send_item(OP_BYTE, q[i]);
		end
	endtask

	task automatic random_frame();
		byte_q_t    q;
		logic [7:0] fc;
		int         pick;
		int         cut;
		pick = $urandom_range(99);
		if (pick < 60) begin
			send_bytes(legal_frame($urandom_range(9) == 0));
		end else if (pick < 68) begin
			// exception reply
			send_bytes({rand_byte(), rand_byte() | 8'h80, rand_byte()});
		end else if (pick < 75) begin
			do begin
				fc = rand_byte() & 8'h7F;
			end while (is_legal(fc));
			send_bytes({rand_byte(), fc});
		end else if (pick < 88) begin
			// reply cut short by a timeout
			q = legal_frame(1'b0);
			cut = $urandom_range(0, q.size() - 1);
			while (q.size() > cut) begin
				void'(q.pop_back());
			end
			send_bytes(q);
			send_item(OP_TIMEOUT, rand_byte());
		end else begin
			// line noise, then a timeout to resynchronise
			repeat ($urandom_range(1, 4)) begin
				send_item(($urandom_range(99) < 30) ? OP_TIMEOUT : OP_BYTE, rand_byte());
			end
			send_item(OP_TIMEOUT, rand_byte());
		end
	endtask

	// Wait for all predicted results, then for the pipeline to empty
	task automatic drain_results();
		int n;
		n = 0;
		while (sb.pending() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [7:0] lim);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lim;
		cur_max = lim;
		@(posedge clk);
		sb.count_limit = lim;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(int tx, int rx, logic [7:0] lim);
		int first;
		tx_idle = tx;
		rx_idle = rx;
		write_limit(lim);
		first = sb.n_in;
		while (sb.n_in - first < 400) begin
			random_frame();
		end
		in_valid <= 1'b0;
		drain_results();
	endtask

	// Stimulus
	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 8'd0;
		in_valid <= 1'b0;
		op <= OP_BYTE;
		rx_byte <= 8'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases at the reset byte count limit
		send_item(OP_TIMEOUT, 8'h00);                           // timeout, no address
		send_bytes(add_crc({8'hFF, FC_READ_EXC_STATUS, 8'h00}, 1'b0));
		send_bytes({8'h00, 8'hFF, 8'h00});                      // exception reply
		send_bytes({8'h11, 8'h00});                             // illegal function
		send_bytes({8'h22, FC_READ_HOLDING, 8'hFE});            // count over limit
		send_bytes(add_crc({8'h33, FC_REPORT_ID, 8'h00}, 1'b1)); // zero count, bad CRC
		send_bytes({8'h44, FC_WRITE_COIL, 8'hA5, 8'h5A});
		send_item(OP_TIMEOUT, 8'hFF);                           // timeout mid-frame
		in_valid <= 1'b0;
		drain_results();

		mid_max = 8'($urandom_range(1, 254));
		run_phase(35, 56, 8'd0);
		run_phase(56, 35, 8'd255);
		run_phase(0, 0, mid_max);

		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
		end
		$display("Covered %0d input and %0d result transactions, %0d frames closed ok,",
			sb.n_in, sb.n_out, sb.ok_frames);
		$display("with byte count limits 253, 0, 255 and %0d under three idling patterns.",
			mid_max);
		if (sb.errors == 0) begin
			$display("modbus_rtu_response_deframer verification clean");
		end else begin
			$display("modbus_rtu_response_deframer verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/mrtu_pkg.sv
hdl/mrtu_frame_step.sv
hdl/modbus_rtu_response_deframer.sv
tb/sv/tb.sv
